/* rtl/tlik_pkg.sv */
// Shared constants for the two-link inverse kinematics block.
package tlik_pkg;

   // Defaults of the top-level parameters
   localparam int COORD_WIDTH_DEF = 16;
   localparam int CORDIC_ITER_DEF = 16;

   // Field widths
   localparam int LINK_W  = 15;
   localparam int ANGLE_W = 17;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LINK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LINK = 2'd1;
   localparam logic [LINK_W-1:0]    LINK_RESET     = 15'd1600;

   // Datapath widths
   localparam int NUM_W      = 36;  // cosine numerators and CORDIC operands
   localparam int CORDIC_W   = 43;  // rotator word, normalized to bit 39
   localparam int ACC_W      = 32;  // angle accumulator, 2^-16 hundredths of a degree
   localparam int NORM_BIT   = 39;
   localparam int NORM_STEPS = 6;   // shift by 32, 16, 8, 4, 2, 1
   localparam int SQRT_STEPS = 32;  // one root bit per stage
   localparam int ANGLE_FRAC_BITS = 16;

   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 32'sd589824000;

   // atan(2^-i) in 2^-16 hundredths of a degree
   localparam logic signed [ACC_W-1:0] ATAN_TABLE [0:31] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466765,   32'sd733385,    32'sd366693,   32'sd183346,
      32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45,
      32'sd22,        32'sd11,        32'sd6,        32'sd3,
      32'sd1,         32'sd1,         32'sd0,        32'sd0
   };

endpackage

/* rtl/tlik_if.sv */
// Handshake channel interfaces: target words, joint-angle words and register writes.
interface tlik_req_if #(parameter int COORD_WIDTH = tlik_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;
   modport source (output valid, output target_x, output target_y, input ready);
   modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface tlik_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tlik_pkg::ANGLE_W-1:0] first_joint_angle;
   logic signed [tlik_pkg::ANGLE_W-1:0] second_joint_angle;
   logic                                 unreachable;
   modport source (output valid, output first_joint_angle, output second_joint_angle,
                   output unreachable, input ready);
   modport sink   (input valid, input first_joint_angle, input second_joint_angle,
                   input unreachable, output ready);
endinterface

interface tlik_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tlik_pkg::CSR_IDX_W-1:0]   index;
   logic [tlik_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tlik_cordic.sv */
// Pipelined vectoring CORDIC: angle of a vector, with normalize and quadrant fold stages.
module tlik_cordic #(
   parameter int ITERATIONS = tlik_pkg::CORDIC_ITER_DEF
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [tlik_pkg::NUM_W-1:0]   vert_in,
   input  logic signed [tlik_pkg::NUM_W-1:0]   horz_in,
   output logic signed [tlik_pkg::ACC_W-1:0]   angle_out
);
   import tlik_pkg::*;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] a;
      logic signed [CORDIC_W-1:0] b;
   } vec_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] a;
      logic signed [CORDIC_W-1:0] b;
      logic signed [ACC_W-1:0]    acc;
   } rot_type;

   // Shift both parts left by st when the larger magnitude stays below 2^40
   function automatic vec_type norm_step(vec_type v, int st);
      logic [CORDIC_W-1:0] mag_a;
      logic [CORDIC_W-1:0] mag_b;
      logic [CORDIC_W-1:0] mag_or;
      vec_type             r;
      mag_a  = v.a[CORDIC_W-1] ? CORDIC_W'(-v.a) : CORDIC_W'(v.a);
      mag_b  = v.b[CORDIC_W-1] ? CORDIC_W'(-v.b) : CORDIC_W'(v.b);
      mag_or = mag_a | mag_b;
      r = v;
      if ((mag_or >> (NORM_BIT + 1 - st)) == '0) begin
         r.a = v.a <<< st;
         r.b = v.b <<< st;
      end
      return r;
   endfunction

   vec_type                 in_vec;
   vec_type                 nv_ff [0:NORM_STEPS-1];
   rot_type                 pr_in;
   rot_type                 pr_ff;
   rot_type                 it_ff [0:ITERATIONS-1];

   assign in_vec.a = CORDIC_W'(horz_in);
   assign in_vec.b = CORDIC_W'(vert_in);

   // Normalize: one binary shift step per stage
   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en) begin
               nv_ff[j] <= norm_step(in_vec, 32 >> j);
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (en) begin
               nv_ff[j] <= norm_step(nv_ff[j-1], 32 >> j);
            end
         end
      end
   end

   // Fold a left-half vector into the right half by a quarter turn
   always_comb begin
      pr_in.a   = nv_ff[NORM_STEPS-1].a;
      pr_in.b   = nv_ff[NORM_STEPS-1].b;
      pr_in.acc = '0;
      if (nv_ff[NORM_STEPS-1].a < 0) begin
         if (nv_ff[NORM_STEPS-1].b >= 0) begin
            pr_in.a   = nv_ff[NORM_STEPS-1].b;
            pr_in.b   = -nv_ff[NORM_STEPS-1].a;
            pr_in.acc = QUARTER_TURN;
         end else begin
            pr_in.a   = -nv_ff[NORM_STEPS-1].b;
            pr_in.b   = nv_ff[NORM_STEPS-1].a;
            pr_in.acc = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_ff <= pr_in;
      end
   end

   // Rotate toward the x axis, one micro-rotation per stage
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      rot_type src;
      rot_type nxt;
      if (i == 0) begin : g_src0
         assign src = pr_ff;
      end else begin : g_srcn
         assign src = it_ff[i-1];
      end
      always_comb begin
         nxt = src;
         if (src.b >= 0) begin
            nxt.a   = src.a + (src.b >>> i);
            nxt.b   = src.b - (src.a >>> i);
            nxt.acc = src.acc + ATAN_TABLE[i];
         end else begin
            nxt.a   = src.a - (src.b >>> i);
            nxt.b   = src.b + (src.a >>> i);
            nxt.acc = src.acc - ATAN_TABLE[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            it_ff[i] <= nxt;
         end
      end
   end

   assign angle_out = it_ff[ITERATIONS-1].acc;

endmodule

/* rtl/two_link_inverse_kinematics.sv */
// Top level: two-link planar inverse kinematics pipeline with output skid buffer.
//
// Takes one target word per cycle while req_if.ready is high and returns one angle word
// per target, in order. The pipeline has four stages of squaring and reach checks, a
// 32-stage bit-per-stage integer square root, three parallel CORDIC pipelines (six
// normalize stages, a quadrant fold and one stage per iteration) and two stages that
// combine and scale the angles. A two-entry output (result register plus skid) lets the
// pipeline take one more target as the consumer stalls; after that req_if.ready drops
// until the skid drains. Targets at the origin, out of reach, or with a zero link length
// come back with unreachable set and both angles zero. Link lengths are written through
// csr_if and must only change while no target is in flight.
module two_link_inverse_kinematics #(
   parameter int COORD_WIDTH       = tlik_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITER_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tlik_req_if.sink   req_if,
   tlik_rsp_if.source rsp_if,
   tlik_csr_if.sink   csr_if
);
   import tlik_pkg::*;

   localparam int R2W        = 2 * COORD_WIDTH;
   localparam int CMPW       = (R2W > 33) ? R2W : 33;
   localparam int CORDIC_LAT = NORM_STEPS + 1 + CORDIC_ITERATIONS;
   localparam int DEPTH      = 4 + SQRT_STEPS + CORDIC_LAT + 2;
   localparam int SUM_W      = ACC_W + 1;

   typedef struct packed {
      logic signed [NUM_W-1:0] num1;
      logic signed [NUM_W-1:0] num2;
      logic signed [NUM_W-1:0] elev_v;
      logic signed [NUM_W-1:0] elev_h;
      logic                    unreach;
   } side_type;

   // Truncate toward zero when dropping the fraction bits
   function automatic logic signed [ANGLE_W-1:0] scale_angle(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v[SUM_W-1] ? v + SUM_W'((1 << ANGLE_FRAC_BITS) - 1) : v;
      return ANGLE_W'(t >>> ANGLE_FRAC_BITS);
   endfunction

   logic                    en;
   logic                    in_accept;
   logic [DEPTH-1:0]        vld_ff;

   logic [LINK_W-1:0]       upper_ff;
   logic [LINK_W-1:0]       lower_ff;

   // stage A
   logic [R2W-1:0]          xsq_ff;
   logic [R2W-1:0]          ysq_ff;
   logic [2*LINK_W-1:0]     l1sq_a_ff;
   logic [2*LINK_W-1:0]     l2sq_a_ff;
   logic [31:0]             sum2_a_ff;
   logic [2*LINK_W-1:0]     diff2_a_ff;
   logic signed [COORD_WIDTH-1:0] y_a_ff;
   logic [COORD_WIDTH:0]    absx_a_ff;
   logic                    zlink_a_ff;
   logic [LINK_W:0]         lsum_a;
   logic [LINK_W-1:0]       ldiff_a;
   logic [COORD_WIDTH:0]    absx_a;

   // stage B
   logic [R2W-1:0]          r2_b_ff;
   logic [2*LINK_W-1:0]     l1sq_b_ff;
   logic [2*LINK_W-1:0]     l2sq_b_ff;
   logic [31:0]             sum2_b_ff;
   logic [2*LINK_W-1:0]     diff2_b_ff;
   logic signed [COORD_WIDTH-1:0] y_b_ff;
   logic [COORD_WIDTH:0]    absx_b_ff;
   logic                    zlink_b_ff;

   // stage C
   logic [CMPW-1:0]         r2x_c;
   logic [31:0]             r2lo_c;
   logic [31:0]             u_c_ff;
   logic [31:0]             w_c_ff;
   side_type                side_c_ff;

   // square root and side data
   logic [63:0]             sq_v_ff [0:SQRT_STEPS];
   logic [63:0]             sq_r_ff [0:SQRT_STEPS];
   side_type                side_ff [0:SQRT_STEPS];

   // CORDIC
   logic signed [NUM_W-1:0] root_s;
   logic signed [ACC_W-1:0] ang1;
   logic signed [ACC_W-1:0] ang2;
   logic signed [ACC_W-1:0] elev;
   logic                    unr_ff [0:CORDIC_LAT-1];

   // stage E and output
   logic signed [SUM_W-1:0]   fsum_e_ff;
   logic signed [SUM_W-1:0]   ssum_e_ff;
   logic                      unr_e_ff;
   logic signed [ANGLE_W-1:0] out_a1_ff;
   logic signed [ANGLE_W-1:0] out_a2_ff;
   logic                      out_unr_ff;

   logic                      skid_vld_ff;
   logic signed [ANGLE_W-1:0] skid_a1_ff;
   logic signed [ANGLE_W-1:0] skid_a2_ff;
   logic                      skid_unr_ff;

   // Advance the whole pipeline while the skid is empty
   assign en           = !skid_vld_ff;
   assign req_if.ready = en;
   assign in_accept    = req_if.valid && en;
   assign csr_if.ready = 1'b1;

   // Link length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= LINK_RESET;
         lower_ff <= LINK_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.index == CSR_UPPER_LINK) begin
            upper_ff <= csr_if.data[LINK_W-1:0];
         end else if (csr_if.index == CSR_LOWER_LINK) begin
            lower_ff <= csr_if.data[LINK_W-1:0];
         end
      end
   end

   // Valid bits travel with the words
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_accept};
      end
   end

   // Stage A: squares of coordinates and link terms
   assign lsum_a  = (LINK_W+1)'(upper_ff) + (LINK_W+1)'(lower_ff);
   assign ldiff_a = (upper_ff > lower_ff) ? upper_ff - lower_ff : lower_ff - upper_ff;
   assign absx_a  = req_if.target_x[COORD_WIDTH-1] ? (COORD_WIDTH+1)'(-(COORD_WIDTH+1)'(req_if.target_x))
                                                   : (COORD_WIDTH+1)'(req_if.target_x);

   always_ff @(posedge clock) begin
      if (en) begin
         xsq_ff     <= R2W'(R2W'(req_if.target_x) * R2W'(req_if.target_x));
         ysq_ff     <= R2W'(R2W'(req_if.target_y) * R2W'(req_if.target_y));
         l1sq_a_ff  <= upper_ff * upper_ff;
         l2sq_a_ff  <= lower_ff * lower_ff;
         sum2_a_ff  <= lsum_a * lsum_a;
         diff2_a_ff <= ldiff_a * ldiff_a;
         y_a_ff     <= req_if.target_y;
         absx_a_ff  <= absx_a;
         zlink_a_ff <= (upper_ff == '0) || (lower_ff == '0);
      end
   end

   // Stage B: squared radius
   always_ff @(posedge clock) begin
      if (en) begin
         r2_b_ff    <= xsq_ff + ysq_ff;
         l1sq_b_ff  <= l1sq_a_ff;
         l2sq_b_ff  <= l2sq_a_ff;
         sum2_b_ff  <= sum2_a_ff;
         diff2_b_ff <= diff2_a_ff;
         y_b_ff     <= y_a_ff;
         absx_b_ff  <= absx_a_ff;
         zlink_b_ff <= zlink_a_ff;
      end
   end

   // Stage C: reach check, root factors and cosine numerators
   assign r2x_c  = CMPW'(r2_b_ff);
   assign r2lo_c = 32'(r2x_c);

   always_ff @(posedge clock) begin
      if (en) begin
         u_c_ff            <= sum2_b_ff - r2lo_c;
         w_c_ff            <= r2lo_c - 32'(diff2_b_ff);
         side_c_ff.num1    <= NUM_W'(l2sq_b_ff) + NUM_W'(r2lo_c) - NUM_W'(l1sq_b_ff);
         side_c_ff.num2    <= NUM_W'(l1sq_b_ff) + NUM_W'(r2lo_c) - NUM_W'(l2sq_b_ff);
         side_c_ff.elev_v  <= NUM_W'(y_b_ff);
         side_c_ff.elev_h  <= NUM_W'(absx_b_ff);
         side_c_ff.unreach <= zlink_b_ff || (r2_b_ff == '0) ||
                              (r2x_c > CMPW'(sum2_b_ff)) || (r2x_c < CMPW'(diff2_b_ff));
      end
   end

   // Stage D: radicand
   always_ff @(posedge clock) begin
      if (en) begin
         sq_v_ff[0] <= u_c_ff * w_c_ff;
         sq_r_ff[0] <= '0;
         side_ff[0] <= side_c_ff;
      end
   end

   // Integer square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [64:0] trial;
      assign trial = {1'b0, sq_r_ff[k]} + {1'b0, BIT};
      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, sq_v_ff[k]} >= trial) begin
               sq_v_ff[k+1] <= sq_v_ff[k] - trial[63:0];
               sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
            end else begin
               sq_v_ff[k+1] <= sq_v_ff[k];
               sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
            end
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign root_s = NUM_W'(sq_r_ff[SQRT_STEPS][31:0]);

   // Three angles in parallel
   tlik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_l1 (
      .clock     (clock),
      .en        (en),
      .vert_in   (root_s),
      .horz_in   (side_ff[SQRT_STEPS].num1),
      .angle_out (ang1)
   );

   tlik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_l2 (
      .clock     (clock),
      .en        (en),
      .vert_in   (root_s),
      .horz_in   (side_ff[SQRT_STEPS].num2),
      .angle_out (ang2)
   );

   tlik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_elev (
      .clock     (clock),
      .en        (en),
      .vert_in   (side_ff[SQRT_STEPS].elev_v),
      .horz_in   (side_ff[SQRT_STEPS].elev_h),
      .angle_out (elev)
   );

   // Carry the unreachable flag alongside the rotators
   for (genvar c = 0; c < CORDIC_LAT; c++) begin : g_unr
      always_ff @(posedge clock) begin
         if (en) begin
            if (c == 0) begin
               unr_ff[c] <= side_ff[SQRT_STEPS].unreach;
            end else begin
               unr_ff[c] <= unr_ff[(c == 0) ? 0 : c - 1];
            end
         end
      end
   end

   // Stage E: combine angles
   always_ff @(posedge clock) begin
      if (en) begin
         fsum_e_ff <= SUM_W'(ang2) + SUM_W'(elev);
         ssum_e_ff <= SUM_W'(ang1) + SUM_W'(ang2);
         unr_e_ff  <= unr_ff[CORDIC_LAT-1];
      end
   end

   // Stage F: scale to hundredths, zero out unreachable targets
   always_ff @(posedge clock) begin
      if (en) begin
         out_a1_ff  <= unr_e_ff ? '0 : scale_angle(fsum_e_ff);
         out_a2_ff  <= unr_e_ff ? '0 : scale_angle(ssum_e_ff);
         out_unr_ff <= unr_e_ff;
      end
   end

   // Skid: hold the result word the consumer did not take
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_if.ready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (vld_ff[DEPTH-1] && !rsp_if.ready) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_a1_ff  <= out_a1_ff;
         skid_a2_ff  <= out_a2_ff;
         skid_unr_ff <= out_unr_ff;
      end
   end

   assign rsp_if.valid              = skid_vld_ff || vld_ff[DEPTH-1];
   assign rsp_if.first_joint_angle  = skid_vld_ff ? skid_a1_ff  : out_a1_ff;
   assign rsp_if.second_joint_angle = skid_vld_ff ? skid_a2_ff  : out_a2_ff;
   assign rsp_if.unreachable        = skid_vld_ff ? skid_unr_ff : out_unr_ff;

   // Unreachable words carry zero angles
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.unreachable) |->
      (rsp_if.first_joint_angle == '0 && rsp_if.second_joint_angle == '0))
      else $error("unreachable word with nonzero angles");

   // A held skid word stays put until taken
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_if.ready) |=>
      (skid_vld_ff && $stable(skid_a1_ff) && $stable(skid_a2_ff)))
      else $error("skid word changed while stalled");

   // A write to the upper link register lands
   a_upper_write: assert property (@(posedge clock) disable iff (reset)
      (csr_if.valid && csr_if.ready && csr_if.index == CSR_UPPER_LINK) |=>
      (upper_ff == $past(csr_if.data[LINK_W-1:0])))
      else $error("upper link write lost");

   // No input word is taken while the skid holds a word
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> !in_accept)
      else $error("word accepted with full skid");

endmodule

/* sim/tb_two_link_inverse_kinematics.sv */
// Testbench for two_link_inverse_kinematics: directed and random targets checked against a predictor.
module tb_two_link_inverse_kinematics;
   timeunit 1ns;
   timeprecision 1ps;
   import tlik_pkg::*;

   localparam int COORD_W = COORD_WIDTH_DEF;
   localparam int ITERS   = CORDIC_ITER_DEF;
   localparam int LATENCY = 4 + 32 + 7 + ITERS + 2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct {
      logic signed [ANGLE_W-1:0] first_angle;
      logic signed [ANGLE_W-1:0] second_angle;
      logic                      unreachable;
   } joint_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlik_req_if #(.COORD_WIDTH(COORD_W)) req_if ();
   tlik_rsp_if rsp_if ();
   tlik_csr_if csr_if ();

   two_link_inverse_kinematics #(.COORD_WIDTH(COORD_W), .CORDIC_ITERATIONS(ITERS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Link lengths as the block should hold them
   longint         upper_len = LINK_RESET;
   longint         lower_len = LINK_RESET;
   joint_word_type pending_angles[$];
   int             mismatches = 0;
   int             words_sent = 0;
   int             words_checked = 0;
   int             unreach_seen = 0;
   int             sender_idle_pct = 0;
   int             receiver_idle_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("TB_ERROR");
      $finish;
   end

   // Exact integer square root, one result bit per pass
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Vectoring rotator: angle of (a, b) in 2^-16 hundredths of a degree
   function automatic longint vector_angle(longint b, longint a);
      longint acc = 0;
      longint ma, mb, t, da, db;
      if (a == 0 && b == 0) return 0;
      for (int n = 0; n < 64; n++) begin
         ma = a < 0 ? -a : a;
         mb = b < 0 ? -b : b;
         if ((ma > mb ? ma : mb) >= (64'sd1 <<< NORM_BIT)) break;
         a = a * 2;
         b = b * 2;
      end
      // fold the left half plane by a quarter turn
      if (a < 0) begin
         t = a;
         if (b >= 0) begin
            a = b;
            b = -t;
            acc = QUARTER_TURN;
         end else begin
            a = -b;
            b = t;
            acc = -QUARTER_TURN;
         end
      end
      for (int n = 0; n < ITERS; n++) begin
         da = b >>> (n % 32);
         db = a >>> (n % 32);
         if (b >= 0) begin
            a += da;
            b -= db;
            acc += ATAN_TABLE[n % 32];
         end else begin
            a -= da;
            b += db;
            acc -= ATAN_TABLE[n % 32];
         end
      end
      return acc;
   endfunction

   function automatic joint_word_type solve_joints(logic signed [COORD_W-1:0] tx,
                                                   logic signed [COORD_W-1:0] ty);
      joint_word_type  w;
      longint          x = tx;
      longint          y = ty;
      longint          r2, sum2, diff2, num1, num2, ang1, ang2, elev;
      longint unsigned s;
      r2    = x * x + y * y;
      sum2  = (upper_len + lower_len) * (upper_len + lower_len);
      diff2 = (upper_len - lower_len) * (upper_len - lower_len);
      w.first_angle  = '0;
      w.second_angle = '0;
      w.unreachable  = 1'b1;
      if (upper_len == 0 || lower_len == 0 || r2 == 0 || r2 > sum2 || r2 < diff2) return w;
      s    = int_sqrt(longint'(sum2 - r2) * longint'(r2 - diff2));
      num1 = lower_len * lower_len + r2 - upper_len * upper_len;
      num2 = upper_len * upper_len + r2 - lower_len * lower_len;
      ang1 = vector_angle(longint'(s), num1);
      ang2 = vector_angle(longint'(s), num2);
      elev = vector_angle(y, x < 0 ? -x : x);
      w.first_angle  = ANGLE_W'((ang2 + elev) / 65536);
      w.second_angle = ANGLE_W'((ang1 + ang2) / 65536);
      w.unreachable  = 1'b0;
      return w;
   endfunction

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Compare each accepted angle word with the oldest prediction
   always @(posedge clock) begin
      joint_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_angles.size() == 0) begin
            mismatches++;
            $display("%t unexpected word: first=%0d second=%0d unreach=%0b", $time,
                     rsp_if.first_joint_angle, rsp_if.second_joint_angle, rsp_if.unreachable);
         end else begin
            want = pending_angles.pop_front();
            words_checked++;
            if (want.unreachable) unreach_seen++;
            if (rsp_if.first_joint_angle !== want.first_angle ||
                rsp_if.second_joint_angle !== want.second_angle ||
                rsp_if.unreachable !== want.unreachable) begin
               mismatches++;
               $display("%t mismatch: expected %0d %0d %0b, actual %0d %0d %0b", $time,
                        want.first_angle, want.second_angle, want.unreachable,
                        rsp_if.first_joint_angle, rsp_if.second_joint_angle,
                        rsp_if.unreachable);
            end
         end
      end
   end

   // Send one target word, idling first at the current rate
   task automatic send_target(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.target_x <= tx;
      req_if.target_y <= ty;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_angles.push_back(solve_joints(tx, ty));
      words_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Write one link register once nothing is in flight
   task automatic write_link(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_UPPER_LINK) upper_len = value & 16'h7FFF;
      else if (idx == CSR_LOWER_LINK) lower_len = value & 16'h7FFF;
   endtask

   task automatic set_links(logic [CSR_DATA_W-1:0] l1, logic [CSR_DATA_W-1:0] l2);
      write_link(CSR_UPPER_LINK, l1);
      write_link(CSR_LOWER_LINK, l2);
   endtask

   // Mostly targets inside the reach box, some anywhere in the coordinate range
   task automatic send_random_targets(int count);
      longint reach;
      int     span;
      for (int i = 0; i < count; i++) begin
         reach = upper_len + lower_len;
         span  = reach > 32767 ? 32767 : int'(reach);
         if ($urandom_range(9) < 8)
            send_target(COORD_W'($urandom_range(2 * span) - span),
                        COORD_W'($urandom_range(2 * span) - span));
         else
            send_target(COORD_W'($urandom), COORD_W'($urandom));
      end
   endtask

   task automatic test_directed_targets();
      set_links(16'd1600, 16'd1600);
      send_target(16'sd0, 16'sd0);
      send_target(-16'sd32768, -16'sd32768);
      send_target(16'sd32767, 16'sd32767);
      send_target(16'sd3200, 16'sd0);
      send_target(16'sd0, 16'sd3200);
      send_target(-16'sd3200, 16'sd0);
      send_target(16'sd0, -16'sd3200);
      send_target(16'sd3201, 16'sd0);
      send_target(16'sd1, 16'sd0);
      send_target(-16'sd1, -16'sd1);
      send_target(16'sd1600, -16'sd1600);
      send_target(-16'sd2000, 16'sd1000);
      // unequal links: inner boundary of the annulus
      set_links(16'd1000, 16'd400);
      send_target(16'sd600, 16'sd0);
      send_target(16'sd599, 16'sd0);
      send_target(16'sd0, -16'sd1400);
      send_target(-16'sd700, 16'sd500);
   endtask

   task automatic test_link_extremes();
      set_links(16'd1, 16'd1);
      send_target(16'sd1, 16'sd1);
      send_target(16'sd2, 16'sd0);
      send_target(16'sd0, -16'sd1);
      set_links(16'h7FFF, 16'h7FFF);
      send_random_targets(12);
      send_target(-16'sd32768, 16'sd32767);
      set_links(16'd1, 16'h7FFF);
      send_target(16'sd32767, 16'sd0);
      send_random_targets(6);
      // zero link lengths and top-bit masking
      set_links(16'h8000, 16'd1600);
      send_target(16'sd1000, 16'sd1000);
      set_links(16'd1600, 16'd0);
      send_target(16'sd1000, 16'sd1000);
      // writes to an unused index must not land anywhere
      set_links(16'd1234, 16'd2345);
      write_link(CSR_UNUSED_IDX, 16'hFFFF);
      write_link(CSR_UNUSED_IDX, 16'h0000);
      send_random_targets(10);
   endtask

   task automatic test_random_phase(int src_pct, int sink_pct, int count);
      sender_idle_pct   = src_pct;
      receiver_idle_pct = sink_pct;
      for (int chunk = 0; chunk < 4; chunk++) begin
         case ($urandom_range(3))
            0: set_links(16'd1600, 16'd1600);
            1: set_links(16'($urandom_range(32767, 1)), 16'($urandom_range(32767, 1)));
            2: set_links(16'($urandom_range(4000, 1)), 16'($urandom_range(4000, 1)));
            default: set_links(16'($urandom_range(20000, 8000)), 16'($urandom_range(16000, 1)));
         endcase
         send_random_targets(count / 4);
      end
   endtask

   task automatic test_full_pause();
      sender_idle_pct = 0;
      send_random_targets(30);
      drain();
      send_random_targets(30);
   endtask

   initial begin
      req_if.valid    <= 1'b0;
      req_if.target_x <= '0;
      req_if.target_y <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_targets();
      test_link_extremes();
      test_random_phase(37, 54, 520);
      test_random_phase(54, 37, 520);
      test_random_phase(0, 0, 520);
      test_full_pause();
      drain();
      $display("Covered %0d targets, %0d results checked (%0d unreachable)",
               words_sent, words_checked, unreach_seen);
      $display("Link settings included extremes, zero lengths and ignored register writes");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
